/* hw/rtl/lsqp_pkg.sv */
// Shared types and constants for the LED symbol queue player.
// No dependencies; imported by the top level.
`default_nettype none

package lsqp_pkg;

	localparam int QUEUE_DEPTH_DEFAULT = 16;
	localparam int SYM_W               = 40;

	localparam logic [7:0] HOLD_TICKS = 8'hff;
	localparam logic [7:0] TICK_MAX   = 8'hff;

	typedef logic [1:0] op_t;
	localparam op_t OP_ENQ     = 2'd0;
	localparam op_t OP_CLR_ENQ = 2'd1;
	localparam op_t OP_TICK    = 2'd2;

	// packed so that red sits in the lowest byte, as on the input bus
	typedef struct packed {
		logic [7:0] pause;
		logic [7:0] on;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} sym_t;

endpackage

`default_nettype wire

/* hw/rtl/lsqp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the symbol ring of the player.
`default_nettype none

module lsqp_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/led_symbol_queue_player.sv */
// Top level of the LED symbol queue player: control, counters and result register.
// Depends on lsqp_pkg and lsqp_ram.
`default_nettype none

// Plays a ring of LED symbols (color, on time, pause). Input beats carry an
// enqueue, a clear-then-enqueue or a tick (in s_tuser); every input beat gives
// exactly one result beat with the color now shown, an accepted flag and an
// empty event. Taking a beat reads the ring entry at the read index out of the
// synchronous RAM; the ST_EXEC state then updates indices, counters and color.
// A new beat is taken once that update is done and the result register is
// free or being drained, so a beat is never taken while the last is in flight.
// The ring holds QUEUE_DEPTH-1 symbols; its entries need no clearing after reset.
module led_symbol_queue_player
	import lsqp_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// red[7:0], green[15:8], blue[23:16], on_ticks[31:24], pause_ticks[39:32]
	input  wire logic [39:0] s_tdata,
	// operation[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// led_red[7:0], led_green[15:8], led_blue[23:16], accepted[24],
	// empty_event[25], zero[31:26]
	output logic      [31:0] m_tdata
);

	localparam int IW = $clog2(QUEUE_DEPTH);

	typedef enum logic {ST_IDLE, ST_EXEC} state_t;

	state_t         state_q;
	op_t            op_q;
	sym_t           sym_q;
	logic [IW-1:0]  wi_q, ri_q;
	logic           playing_q, pause_q;
	logic [7:0]     on_q, pz_q, el_q;
	logic [23:0]    color_q;
	logic           m_tvalid_q, acc_q, empty_q;

	logic [SYM_W-1:0] ram_rdata;
	sym_t             rd_sym;
	logic             ram_we;
	logic [IW-1:0]    ram_waddr;

	logic [IW-1:0]  n_wi, n_ri;
	logic           n_playing, n_pause;
	logic [7:0]     n_on, n_pz, n_el;
	logic [23:0]    n_color;
	logic           n_acc, n_empty;

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
		return (i == IW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	wire in_fire = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);

	assign rd_sym = sym_t'(ram_rdata);

	lsqp_ram #(
		.WIDTH (SYM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (sym_q),
		.re    (in_fire),
		.raddr (ri_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		logic       do_adv;
		sym_t       adv_sym;
		logic [7:0] el_inc;

		n_wi      = wi_q;
		n_ri      = ri_q;
		n_playing = playing_q;
		n_pause   = pause_q;
		n_on      = on_q;
		n_pz      = pz_q;
		n_el      = el_q;
		n_color   = color_q;
		n_acc     = 1'b0;
		n_empty   = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = wi_q;
		do_adv    = 1'b0;
		adv_sym   = rd_sym;
		el_inc    = (el_q == TICK_MAX) ? TICK_MAX : el_q + 8'd1;

		case (op_q)
			OP_ENQ, OP_CLR_ENQ: begin
				if (op_q == OP_CLR_ENQ) begin
					n_wi      = '0;
					n_ri      = '0;
					n_playing = 1'b0;
				end
				if (ring_next(n_wi) != n_ri) begin
					ram_we    = 1'b1;
					ram_waddr = n_wi;
					n_wi      = ring_next(n_wi);
					n_acc     = 1'b1;
					// fresh symbol is the only one queued: start it from the beat
					if (!n_playing && ring_next(n_ri) == n_wi) begin
						do_adv  = 1'b1;
						adv_sym = sym_q;
					end
				end
			end
			OP_TICK: begin
				if (playing_q) begin
					n_el = el_inc;
					if (!pause_q) begin
						if (el_inc >= on_q) begin
							if (pz_q != 8'd0) begin
								n_color = '0;
								n_pause = 1'b1;
								n_el    = '0;
							end else begin
								do_adv = 1'b1;
							end
						end
					end else if (el_inc >= pz_q) begin
						do_adv = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		if (do_adv) begin
			if (n_ri == n_wi) begin
				n_playing = 1'b0;
				n_color   = '0;
				n_empty   = 1'b1;
			end else begin
				n_color = {adv_sym.blue, adv_sym.green, adv_sym.red};
				if (adv_sym.on < HOLD_TICKS) begin
					n_ri      = ring_next(n_ri);
					n_playing = 1'b1;
					n_on      = adv_sym.on;
					n_pz      = adv_sym.pause;
					n_pause   = (adv_sym.on == 8'd0);
					n_el      = '0;
				end else begin
					// hold symbol: keep the color, flush the ring
					n_ri      = '0;
					n_wi      = '0;
					n_playing = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wi_q       <= '0;
			ri_q       <= '0;
			playing_q  <= 1'b0;
			pause_q    <= 1'b0;
			on_q       <= '0;
			pz_q       <= '0;
			el_q       <= '0;
			color_q    <= '0;
			m_tvalid_q <= 1'b0;
			acc_q      <= 1'b0;
			empty_q    <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q    <= ST_IDLE;
					wi_q       <= n_wi;
					ri_q       <= n_ri;
					playing_q  <= n_playing;
					pause_q    <= n_pause;
					on_q       <= n_on;
					pz_q       <= n_pz;
					el_q       <= n_el;
					color_q    <= n_color;
					acc_q      <= n_acc;
					empty_q    <= n_empty;
					m_tvalid_q <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// beat payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= op_t'(s_tuser);
			sym_q <= sym_t'(s_tdata);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, empty_q, acc_q, color_q};

`ifndef SYNTHESIS
	a_idle_ring_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!playing_q |-> (wi_q == ri_q))
		else $error("ring holds symbols while player is stopped");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_EXEC))
		else $error("result beat without an update cycle");

	a_empty_led_off: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && empty_q) |-> (color_q == 24'd0) && !acc_q)
		else $error("empty event with LED lit or enqueue accepted");

	a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !s_tready)
		else $error("input taken while result register is blocked");
`endif

endmodule

`default_nettype wire

/* tb/sv/led_symbol_queue_player_tb.sv */
// Testbench for the LED symbol queue player: a directed pass over the special
// cases, then random enqueue/tick traffic (with clears and unused codes) scored against an in-bench player model.
// Depends on lsqp_pkg and the led_symbol_queue_player RTL.
`timescale 1ns / 100ps

module led_symbol_queue_player_tb;
	import lsqp_pkg::*;

	localparam int          QDEPTH      = QUEUE_DEPTH_DEFAULT;
	localparam int          RAND_BEATS  = 1600;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          DRAIN_LIMIT = 10000;
	localparam op_t         OP_UNUSED   = 2'd3;

	// result bus layout, highest field first
	typedef struct packed {
		logic [5:0] pad;
		logic       empty_ev;
		logic       acc;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} led_result_t;

	typedef struct {
		op_t  op;
		sym_t sym;
	} symbol_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	led_symbol_queue_player u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	symbol_beat_t symbol_beats[$];
	led_result_t  pending_leds[$];

	int          total_beats;
	int          beats_in;
	int          beats_out;
	int          mismatches;
	int unsigned cycles;
	bit          in_beat;

	// player model state
	sym_t        ring[QDEPTH];
	int unsigned wr_ptr;
	int unsigned rd_ptr;
	bit          playing;
	bit          in_pause;
	logic [7:0]  cur_on;
	logic [7:0]  cur_pause;
	logic [7:0]  elapsed;
	logic [7:0]  shown_r, shown_g, shown_b;

	int n_ticks, n_stored, n_refused, n_clears, n_empty, n_holds, n_unused;

	function automatic int unsigned ring_inc(int unsigned i);
		return (i + 1 >= QDEPTH) ? 0 : i + 1;
	endfunction

	// load the next queued symbol; returns 1 when the ring was dry
	function automatic bit start_next();
		sym_t s;
		if (rd_ptr == wr_ptr) begin
			playing = 1'b0;
			{shown_r, shown_g, shown_b} = '0;
			return 1'b1;
		end
		s = ring[rd_ptr];
		shown_r = s.red;
		shown_g = s.green;
		shown_b = s.blue;
		if (s.on != HOLD_TICKS) begin
			rd_ptr    = ring_inc(rd_ptr);
			playing   = 1'b1;
			cur_on    = s.on;
			cur_pause = s.pause;
			in_pause  = (s.on == 8'd0);
			elapsed   = 8'd0;
		end else begin
			// hold: color stays, queue flushed
			rd_ptr  = 0;
			wr_ptr  = 0;
			playing = 1'b0;
			n_holds++;
		end
		return 1'b0;
	endfunction

	function automatic led_result_t led_step(op_t op, sym_t s);
		led_result_t r;
		r = '0;
		case (op)
			OP_ENQ, OP_CLR_ENQ: begin
				if (op == OP_CLR_ENQ) begin
					wr_ptr  = 0;
					rd_ptr  = 0;
					playing = 1'b0;
					n_clears++;
				end
				if (ring_inc(wr_ptr) != rd_ptr) begin
					ring[wr_ptr] = s;
					wr_ptr       = ring_inc(wr_ptr);
					r.acc        = 1'b1;
					n_stored++;
					if (!playing && ring_inc(rd_ptr) == wr_ptr)
						void'(start_next());
				end else begin
					n_refused++;
				end
			end
			OP_TICK: begin
				n_ticks++;
				if (playing) begin
					if (elapsed != TICK_MAX)
						elapsed++;
					if (!in_pause) begin
						if (elapsed >= cur_on) begin
							if (cur_pause != 8'd0) begin
								{shown_r, shown_g, shown_b} = '0;
								in_pause = 1'b1;
								elapsed  = 8'd0;
							end else begin
								r.empty_ev = start_next();
							end
						end
					end else if (elapsed >= cur_pause) begin
						r.empty_ev = start_next();
					end
				end
			end
			default: n_unused++;
		endcase
		if (r.empty_ev)
			n_empty++;
		r.red   = shown_r;
		r.green = shown_g;
		r.blue  = shown_b;
		return r;
	endfunction

	function automatic sym_t mk_symbol(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [7:0] on, logic [7:0] pause);
		return {pause, on, b, g, r};
	endfunction

	function automatic sym_t rand_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return sym_t'(w[39:0]);
	endfunction

	// durations mostly short so playback keeps moving, a few over the full range
	function automatic logic [7:0] pick_ticks(int unsigned top);
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 80)
			return 8'($urandom_range(0, 4));
		if (p < 95)
			return 8'($urandom_range(5, 20));
		return 8'($urandom_range(0, top));
	endfunction

	function automatic sym_t rand_symbol();
		sym_t s;
		s       = rand_word();
		s.on    = ($urandom_range(0, 99) < 3) ? HOLD_TICKS : pick_ticks(254);
		s.pause = pick_ticks(255);
		return s;
	endfunction

	task automatic add_beat(input op_t op, input sym_t s);
		symbol_beat_t b;
		b.op  = op;
		b.sym = s;
		symbol_beats.push_back(b);
	endtask

	task automatic add_ticks(input int n);
		for (int k = 0; k < n; k++)
			add_beat(OP_TICK, rand_word());
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] seen);
		if (seen !== want) begin
			$display("%0t: beat %0d %s expected 0x%02h got 0x%02h",
				$time, beats_out, name, want, seen);
			mismatches++;
		end
	endtask

	// 0: sender 37% idle, receiver 78%; 1: swapped; 2: no idling
	function automatic int idle_phase();
		return (total_beats == 0) ? 2 : (beats_in * 3) / total_beats;
	endfunction

	function automatic bit idle_now(bit sender);
		int ph;
		ph = idle_phase();
		if (ph == 0)
			return $urandom_range(0, 99) < (sender ? 37 : 78);
		if (ph == 1)
			return $urandom_range(0, 99) < (sender ? 78 : 37);
		return 1'b0;
	endfunction

	// source side
	always @(negedge clk) begin
		if (arst_n === 1'b1) begin
			if (!s_tvalid || in_beat) begin
				if (symbol_beats.size() > 0 && !idle_now(1'b1)) begin
					symbol_beat_t b;
					b = symbol_beats.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= b.op;
					s_tdata  <= b.sym;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side
	always @(negedge clk) begin
		if (arst_n === 1'b1)
			m_tready <= !idle_now(1'b0);
	end

	// scoreboard: predict on input beats, compare on output beats
	always @(posedge clk) begin
		led_result_t got, want;
		if (arst_n === 1'b1) begin
			in_beat <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				pending_leds.push_back(led_step(s_tuser, sym_t'(s_tdata)));
				beats_in++;
			end
			if (m_tvalid && m_tready) begin
				got = led_result_t'(m_tdata);
				if (pending_leds.size() == 0) begin
					$display("%0t: unexpected result beat, expected none got 0x%08h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = pending_leds.pop_front();
					check_field("led_red", want.red, got.red);
					check_field("led_green", want.green, got.green);
					check_field("led_blue", want.blue, got.blue);
					check_field("accepted", {7'd0, want.acc}, {7'd0, got.acc});
					check_field("empty_event", {7'd0, want.empty_ev}, {7'd0, got.empty_ev});
					check_field("pad", {2'd0, want.pad}, {2'd0, got.pad});
				end
				beats_out++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d of %0d beats in, %0d results pending",
				$time, beats_in, total_beats, pending_leds.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int kind, n, drain;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_ENQ;
		m_tready = 1'b0;
		cycles   = 0;
		wr_ptr   = 0;
		rd_ptr   = 0;
		playing  = 1'b0;
		in_pause = 1'b0;
		cur_on   = '0;
		cur_pause = '0;
		elapsed  = '0;
		{shown_r, shown_g, shown_b} = '0;

		// directed: idle tick, unused code, zero on-time, zero pause, hold, clear
		add_beat(OP_TICK, mk_symbol(8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
		add_beat(OP_UNUSED, mk_symbol(8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
		add_beat(OP_ENQ, mk_symbol(8'hff, 8'h00, 8'h00, 8'd0, 8'd2));
		add_beat(OP_ENQ, mk_symbol(8'h00, 8'hff, 8'h00, 8'd1, 8'd0));
		add_beat(OP_ENQ, mk_symbol(8'h00, 8'h00, 8'hff, 8'd2, 8'd1));
		add_ticks(7);
		add_beat(OP_ENQ, mk_symbol(8'hff, 8'hff, 8'hff, HOLD_TICKS, 8'd0));
		add_ticks(1);
		add_beat(OP_ENQ, mk_symbol(8'h12, 8'h34, 8'h56, 8'd3, 8'd0));
		add_beat(OP_ENQ, mk_symbol(8'h80, 8'h01, 8'h7f, 8'd254, 8'd255));
		add_beat(OP_CLR_ENQ, mk_symbol(8'h5a, 8'ha5, 8'h3c, 8'd1, 8'd255));
		add_ticks(2);
		add_beat(OP_CLR_ENQ, mk_symbol(8'h00, 8'h00, 8'h00, HOLD_TICKS, 8'd0));
		add_ticks(1);

		// random: mostly bursts of symbols followed by ticks to play them out
		while (symbol_beats.size() < RAND_BEATS) begin
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 17) : $urandom_range(1, 5);
				for (int k = 0; k < n; k++)
					add_beat((k == 0 && $urandom_range(0, 9) == 0) ? OP_CLR_ENQ : OP_ENQ,
						rand_symbol());
				add_ticks($urandom_range(1, 25));
			end else if (kind < 85) begin
				add_ticks($urandom_range(1, 40));
			end else if (kind < 95) begin
				n = $urandom_range(1, 6);
				for (int k = 0; k < n; k++)
					add_beat(op_t'($urandom_range(0, 3)), rand_word());
			end else begin
				add_beat(OP_UNUSED, rand_word());
			end
		end
		total_beats = symbol_beats.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (beats_in < total_beats)
			@(posedge clk);
		drain = 0;
		while (pending_leds.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (16) @(posedge clk);
		if (pending_leds.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_leds.size());
			mismatches += pending_leds.size();
		end

		$display("covered %0d beats: %0d ticks, %0d symbols stored, %0d refused on a full ring",
			total_beats, n_ticks, n_stored, n_refused);
		$display("  %0d clears, %0d hold symbols, %0d empty events, %0d unused codes, %0d errors",
			n_clears, n_holds, n_empty, n_unused, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
